### hw/rtl/jts_pkg.sv
// Shared types and constants of the joint trajectory sampler.
`default_nettype none
package jts_pkg;

   typedef enum logic [1:0] {
      OP_WPOS    = 2'd0,
      OP_WTIME   = 2'd1,
      OP_RESTART = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_START = 2'd2;

   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_STEPS  = 2'd1;
   localparam logic [1:0] CSR_JOINTS = 2'd2;
   localparam logic [1:0] CSR_TIMED  = 2'd3;

   typedef struct packed {
      op_type      op;
      logic [7:0]  wi;
      logic [2:0]  ji;
      logic [31:0] pos;
      logic [31:0] tv;
   } item_type;

   typedef struct packed {
      logic [31:0] period_us;
      logic [8:0]  num_steps;
      logic [3:0]  num_joints;
      logic        timed_mode;
   } cfg_type;

endpackage
`default_nettype wire

### hw/rtl/jts_ifs.sv
// Request and response channel interfaces of the joint trajectory sampler.
`default_nettype none
interface jts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  waypoint_index;
   logic [2:0]  joint_index;
   logic signed [31:0] position;
   logic [31:0] waypoint_time;
   modport source (output valid, action, waypoint_index, joint_index, position,
                   waypoint_time, input ready);
   modport sink (input valid, action, waypoint_index, joint_index, position,
                 waypoint_time, output ready);
endinterface

interface jts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  joint_number;
   logic signed [31:0] position_res;
   logic [31:0] sample_time;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, joint_number, position_res, sample_time, status,
                   last, input ready);
   modport sink (input valid, joint_number, position_res, sample_time, status,
                 last, output ready);
endinterface
`default_nettype wire

### hw/rtl/joint_trajectory_sampler.sv
// Top level of the joint trajectory sampler: CSRs, request queue and engine.
`default_nettype none
// Usage: requests arrive on req_ch. Position and time writes load the waypoint
// tables, a restart clears the step pointer and elapsed time, and a tick
// produces one response per joint on rsp_ch, the final one flagged last.
// The CSR port (csr_we, csr_index, csr_wdata) sets the tick period, waypoint
// count, joint count and timed mode; write it only while the block is idle.
// A two-entry queue sits between the front end and the engine, so requests
// keep being taken while the engine works. Writes and restarts are handled
// in the engine's idle step. A timed tick starts in the idle step, runs the
// step search over the waypoint times (a read and a compare for each), picks
// the segment and reads its start time (only the pick at a trajectory end),
// runs the serial fraction divider (skipped at trajectory ends or when the
// fraction is a full step), and then for each joint does the two position
// reads, the multiply and the emit. An untimed tick skips the search and the
// divider. A tick that reports an error starts in the idle step and then
// emits once per joint. Each table has a single read port. Responses sit in
// an output register; when the receiver stalls the engine holds in its emit
// step and the queue fills, then req_ch.ready drops. Reset clears control
// state and returns the CSRs to their reset values; the tables hold garbage
// until written.
module joint_trajectory_sampler #(
   parameter int MAX_STEPS  = 256,
   parameter int MAX_JOINTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   jts_req_if.sink          req_ch,
   jts_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import jts_pkg::*;

   // Configuration registers with their documented reset values.
   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PERIOD: cfg_in.period_us  = csr_wdata;
            CSR_STEPS:  cfg_in.num_steps  = csr_wdata[8:0];
            CSR_JOINTS: cfg_in.num_joints = csr_wdata[3:0];
            CSR_TIMED:  cfg_in.timed_mode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_us  <= 32'd10000;
         cfg_ff.num_steps  <= 9'd0;
         cfg_ff.num_joints <= 4'd1;
         cfg_ff.timed_mode <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end decodes and buffers requests.
   jts_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // The engine runs each request to completion and drives the responses.
   jts_back #(
      .MAX_STEPS  (MAX_STEPS),
      .MAX_JOINTS (MAX_JOINTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );
endmodule
`default_nettype wire

### hw/rtl/jts_front.sv
// Front end: accepts requests, decodes the action and queues them for the engine.
`default_nettype none
module jts_front (
   input  wire logic          clock,
   input  wire logic          reset,
   jts_req_if.sink            req_ch,
   output jts_pkg::item_type  q_item,
   output logic               q_valid,
   input  wire logic          q_pop
);
   import jts_pkg::*;

   item_type   slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   dec;

   always_comb begin
      dec.op  = op_type'(req_ch.action);
      dec.wi  = req_ch.waypoint_index;
      dec.ji  = req_ch.joint_index;
      dec.pos = req_ch.position;
      dec.tv  = req_ch.waypoint_time;
   end

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push    = req_ch.valid && req_ch.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/jts_back.sv
// Engine: waypoint tables, step search, fraction divider and per-joint blend.
`default_nettype none
module jts_back #(
   parameter int MAX_STEPS  = 256,
   parameter int MAX_JOINTS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire jts_pkg::cfg_type cfg,
   input  wire jts_pkg::item_type q_item,
   input  wire logic          q_valid,
   output logic               q_pop,
   jts_rsp_if.source          rsp_ch
);
   import jts_pkg::*;

   localparam int SPW   = $clog2(MAX_STEPS + 1);
   localparam int TAW   = $clog2(MAX_STEPS);
   localparam int PDEP  = MAX_STEPS * MAX_JOINTS;
   localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;
   localparam int JCW   = $clog2(MAX_JOINTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_SCMP, S_PICK, S_T0, S_DIV, S_RA, S_RB, S_MUL, S_EMIT
   } state_type;

   logic [31:0] tmem [MAX_STEPS];
   logic [31:0] pmem [PDEP];

   state_type   state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in, n_ff, n_in;
   logic [31:0] et_ff, et_in, t_ff, t_in, t1_ff, t1_in, span_ff, span_in;
   logic [31:0] rem_ff, rem_in, p0_ff, p0_in, tq_ff, pq_ff;
   logic        serr_ff, serr_in;
   logic [1:0]  st_ff, st_in;
   logic [SPW-1:0] wpa_ff, wpa_in, wpb_ff, wpb_in;
   logic [16:0] frac_ff, frac_in;
   logic [15:0] q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [JCW-1:0] j_ff, j_in, nj_ff, nj_in;
   logic signed [50:0] prod_ff, prod_in;
   logic        ov_ff, ov_in;
   logic [2:0]  o_jn_ff, o_jn_in;
   logic [31:0] o_pos_ff, o_pos_in, o_t_ff, o_t_in;
   logic [1:0]  o_st_ff, o_st_in;
   logic        o_last_ff, o_last_in;

   logic [TAW-1:0] t_raddr;
   logic [PAW-1:0] p_raddr, p_waddr;
   logic        twe, pwe, ld;
   logic [SPW-1:0] n_c, sp_sat, sp_up;
   logic [JCW-1:0] nj_c;
   logic [32:0] r2;
   logic [31:0] num, t0;
   logic signed [32:0] diff;

   always_comb begin
      n_c = (32'(cfg.num_steps) > MAX_STEPS) ? SPW'(MAX_STEPS) : SPW'(cfg.num_steps);
      if (cfg.num_joints == 4'd0)
         nj_c = JCW'(1);
      else if (32'(cfg.num_joints) > MAX_JOINTS)
         nj_c = JCW'(MAX_JOINTS);
      else
         nj_c = JCW'(cfg.num_joints);
      sp_sat = (sp_ff > n_c) ? n_c : sp_ff;
      sp_up  = (sp_sat < n_c) ? sp_sat + SPW'(1) : sp_sat;
      p_waddr = PAW'(32'(q_item.wi) * MAX_JOINTS + 32'(q_item.ji));
      t0   = tq_ff;
      num  = (t_ff <= t0) ? 32'd0 : t_ff - t0;
      r2   = {rem_ff, 1'b0};
      diff = $signed({pq_ff[31], pq_ff}) - $signed({p0_ff[31], p0_ff});
      ld   = (state_ff == S_EMIT) && (!ov_ff || rsp_ch.ready);
   end

   always_comb begin
      state_in = state_ff;  sp_in = sp_ff;  n_in = n_ff;  et_in = et_ff;
      t_in = t_ff;  t1_in = t1_ff;  span_in = span_ff;  rem_in = rem_ff;
      p0_in = p0_ff;  serr_in = serr_ff;  st_in = st_ff;  wpa_in = wpa_ff;
      wpb_in = wpb_ff;  frac_in = frac_ff;  q_in = q_ff;  cnt_in = cnt_ff;
      j_in = j_ff;  nj_in = nj_ff;  prod_in = prod_ff;
      q_pop = 1'b0;  twe = 1'b0;  pwe = 1'b0;
      t_raddr = TAW'(sp_ff);
      p_raddr = PAW'(32'(wpa_ff) * MAX_JOINTS + 32'(j_ff));
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_WPOS: begin
                     pwe = (32'(q_item.wi) < MAX_STEPS) && (32'(q_item.ji) < MAX_JOINTS);
                  end
                  OP_WTIME: begin
                     twe = (32'(q_item.wi) < MAX_STEPS);
                     if (q_item.wi == 8'd0)
                        serr_in = (q_item.tv != 32'd0);
                  end
                  OP_RESTART: begin
                     sp_in = '0;
                     et_in = 32'd0;
                  end
                  OP_TICK: begin
                     t_in  = et_ff;
                     n_in  = n_c;
                     nj_in = nj_c;
                     j_in  = '0;
                     frac_in = 17'd0;
                     if (cfg.timed_mode && serr_ff) begin
                        st_in = ST_START;
                        state_in = S_EMIT;
                     end else if (n_c == '0) begin
                        st_in = ST_EMPTY;
                        state_in = S_EMIT;
                     end else begin
                        st_in = ST_OK;
                        if (!cfg.timed_mode) begin
                           sp_in  = sp_up;
                           wpa_in = sp_up - SPW'(1);
                           wpb_in = sp_up - SPW'(1);
                           state_in = S_RA;
                        end else begin
                           sp_in = sp_sat;
                           state_in = S_SRD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SRD: begin
            state_in = (sp_ff < n_ff) ? S_SCMP : S_PICK;
         end
         S_SCMP: begin
            if (tq_ff < t_ff) begin
               sp_in = sp_ff + SPW'(1);
               state_in = S_SRD;
            end else begin
               t1_in = tq_ff;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (sp_ff == '0) begin
               wpa_in = '0;
               wpb_in = '0;
               state_in = S_RA;
            end else if (sp_ff == n_ff) begin
               wpa_in = n_ff - SPW'(1);
               wpb_in = n_ff - SPW'(1);
               state_in = S_RA;
            end else begin
               wpa_in = sp_ff - SPW'(1);
               wpb_in = sp_ff;
               t_raddr = TAW'(sp_ff - SPW'(1));
               state_in = S_T0;
            end
         end
         S_T0: begin
            span_in = t1_ff - t0;
            if (t1_ff <= t0 || num >= t1_ff - t0) begin
               frac_in = 17'h10000;
               state_in = S_RA;
            end else begin
               rem_in = num;
               q_in   = 16'd0;
               cnt_in = 4'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // One quotient bit per cycle; the remainder stays below the span.
            if (r2 >= {1'b0, span_ff}) begin
               rem_in = 32'(r2 - {1'b0, span_ff});
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = r2[31:0];
               q_in   = {q_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               frac_in  = {1'b0, q_in};
               state_in = S_RA;
            end
         end
         S_RA: begin
            state_in = S_RB;
         end
         S_RB: begin
            p0_in   = pq_ff;
            p_raddr = PAW'(32'(wpb_ff) * MAX_JOINTS + 32'(j_ff));
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = 51'(diff) * 51'($signed({1'b0, frac_ff}));
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (ld) begin
               if (j_ff + JCW'(1) == nj_ff) begin
                  if (st_ff == ST_OK)
                     et_in = t_ff + cfg.period_us;
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + JCW'(1);
                  if (st_ff == ST_OK)
                     state_in = S_RA;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      o_jn_in = o_jn_ff;  o_pos_in = o_pos_ff;  o_t_in = o_t_ff;
      o_st_in = o_st_ff;  o_last_in = o_last_ff;
      ov_in = (ov_ff && rsp_ch.ready) ? 1'b0 : ov_ff;
      if (ld) begin
         ov_in     = 1'b1;
         o_jn_in   = 3'(j_ff);
         o_pos_in  = (st_ff == ST_OK) ? p0_ff + prod_ff[47:16] : 32'd0;
         o_t_in    = t_ff;
         o_st_in   = st_ff;
         o_last_in = (j_ff + JCW'(1) == nj_ff);
      end
   end

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.joint_number = o_jn_ff;
   assign rsp_ch.position_res = o_pos_ff;
   assign rsp_ch.sample_time  = o_t_ff;
   assign rsp_ch.status       = o_st_ff;
   assign rsp_ch.last         = o_last_ff;

   always_ff @(posedge clock) begin
      if (twe)
         tmem[TAW'(q_item.wi)] <= q_item.tv;
      tq_ff <= tmem[t_raddr];
      if (pwe)
         pmem[p_waddr] <= q_item.pos;
      pq_ff <= pmem[p_raddr];
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;  t_ff <= t_in;  t1_ff <= t1_in;  span_ff <= span_in;
      rem_ff <= rem_in;  p0_ff <= p0_in;  st_ff <= st_in;  wpa_ff <= wpa_in;
      wpb_ff <= wpb_in;  frac_ff <= frac_in;  q_ff <= q_in;  cnt_ff <= cnt_in;
      j_ff <= j_in;  nj_ff <= nj_in;  prod_ff <= prod_in;
      o_jn_ff <= o_jn_in;  o_pos_ff <= o_pos_in;  o_t_ff <= o_t_in;
      o_st_ff <= o_st_in;  o_last_ff <= o_last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         et_ff    <= 32'd0;
         serr_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         et_ff    <= et_in;
         serr_ff  <= serr_in;
         ov_ff    <= ov_in;
      end
   end
endmodule
`default_nettype wire
